// ===== sv/uart_rts_pkg.sv =====
package uart_rts_pkg;

    localparam int CFG_W         = 23;
    localparam int CFG_IDX_W     = 3;
    localparam int COUNT_W       = 4;
    localparam int WORD_W        = 9;
    localparam int BYTE_W        = 8;
    localparam int MAX_DATA_BITS = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BIT_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_INVERT    = 3'd4;

    localparam logic [CFG_W-1:0]   BIT_TICKS_RST      = 23'd694;
    localparam logic [CFG_W-1:0]   START_TICKS_RST    = 23'd1041;
    localparam logic [COUNT_W-1:0] DATA_BIT_COUNT_RST = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_DATA   = 4'b0010,
        PH_PARITY = 4'b0100,
        PH_STOP   = 4'b1000
    } rx_phase_t;

    typedef struct packed {
        logic [CFG_W-1:0]   bit_ticks;
        logic [CFG_W-1:0]   start_ticks;
        logic [COUNT_W-1:0] data_bit_count;
        logic               parity_enable;
        logic               line_invert;
    } rx_cfg_t;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] data;
        logic              parity;
    } rx_result_t;

endpackage

// ===== sv/uart_rts_cfg.sv =====
module uart_rts_cfg
    import uart_rts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output rx_cfg_t              cfg
);

    rx_cfg_t cfg_reg;
    rx_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BIT_TICKS:      cfg_next.bit_ticks      = cfg_data;
                REG_START_TICKS:    cfg_next.start_ticks    = cfg_data;
                REG_DATA_BIT_COUNT: cfg_next.data_bit_count = cfg_data[COUNT_W-1:0];
                REG_PARITY_ENABLE:  cfg_next.parity_enable  = cfg_data[0];
                REG_LINE_INVERT:    cfg_next.line_invert    = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_ticks      <= BIT_TICKS_RST;
            cfg_reg.start_ticks    <= START_TICKS_RST;
            cfg_reg.data_bit_count <= DATA_BIT_COUNT_RST;
            cfg_reg.parity_enable  <= 1'b0;
            cfg_reg.line_invert    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/uart_rts_engine.sv =====
module uart_rts_engine
    import uart_rts_pkg::*;
#(
    parameter int TICK_WIDTH = 23
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       rx_level,
    input  rx_cfg_t    cfg,
    output rx_result_t result
);

    rx_phase_t              phase_reg, phase_next, phase_eff;
    logic [WORD_W-1:0]      shift_reg, shift_next, shift_eff;
    logic [COUNT_W-1:0]     bits_reg, bits_next, bits_eff, bits_inc;
    logic [TICK_WIDTH-1:0]  cd_reg, cd_next, cd_eff;
    logic                   prev_level_reg, prev_level_next;
    logic                   level;
    logic                   sample;
    logic                   emit;
    logic [TICK_WIDTH-1:0]  bit_ticks_w;
    logic [TICK_WIDTH-1:0]  start_w;
    logic [TICK_WIDTH-1:0]  period;
    logic [COUNT_W-1:0]     frame_bits;

    always_comb
    begin
        level       = rx_level ^ cfg.line_invert;
        bit_ticks_w = TICK_WIDTH'(cfg.bit_ticks);
        start_w     = TICK_WIDTH'(cfg.start_ticks);
        period      = (bit_ticks_w == '0) ? TICK_WIDTH'(1) : bit_ticks_w;

        if (cfg.data_bit_count == '0)
            frame_bits = COUNT_W'(1);
        else if (cfg.data_bit_count > COUNT_W'(MAX_DATA_BITS))
            frame_bits = COUNT_W'(MAX_DATA_BITS);
        else
            frame_bits = cfg.data_bit_count;

        phase_eff = phase_reg;
        shift_eff = shift_reg;
        bits_eff  = bits_reg;
        cd_eff    = cd_reg;
        sample    = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (prev_level_reg && !level)
            begin
                phase_eff = PH_DATA;
                shift_eff = '0;
                bits_eff  = '0;
                cd_eff    = start_w;
                sample    = (start_w == '0);
            end
        end
        else
        begin
            cd_eff = (cd_reg != '0) ? cd_reg - TICK_WIDTH'(1) : cd_reg;
            sample = (cd_eff == '0);
        end

        bits_inc   = bits_eff + COUNT_W'(1);
        phase_next = phase_eff;
        shift_next = shift_eff;
        bits_next  = bits_eff;
        cd_next    = cd_eff;
        emit       = 1'b0;

        if (sample)
        begin
            unique case (phase_eff)
                PH_DATA:
                begin
                    cd_next    = period;
                    shift_next = {1'b0, shift_eff[8] | level, shift_eff[7:1]};
                    bits_next  = bits_inc;
                    if (bits_inc >= frame_bits)
                    begin
                        phase_next = cfg.parity_enable ? PH_PARITY : PH_STOP;
                        bits_next  = '0;
                    end
                end
                PH_PARITY:
                begin
                    cd_next    = period;
                    shift_next = {shift_eff[8] | level, shift_eff[7:0]};
                    phase_next = PH_STOP;
                end
                PH_STOP:
                begin
                    emit       = 1'b1;
                    shift_next = '0;
                    cd_next    = '0;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = phase_eff;
                end
            endcase
        end

        prev_level_next = level;
    end

    assign result.emit   = emit;
    assign result.data   = shift_eff[BYTE_W-1:0];
    assign result.parity = shift_eff[BYTE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            shift_reg      <= '0;
            bits_reg       <= '0;
            cd_reg         <= '0;
            prev_level_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            bits_reg       <= bits_next;
            cd_reg         <= cd_next;
            prev_level_reg <= prev_level_next;
        end
    end

    // bit count only runs during data phase
    a_bits_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_DATA |-> bits_reg == '0)
        else $error("bit count not cleared outside data phase");

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg < COUNT_W'(MAX_DATA_BITS))
        else $error("bit count beyond frame length");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> shift_reg == '0)
        else $error("shift word not cleared while idle");

endmodule

// ===== sv/uart_receiver_timed_sampling_core.sv =====
// An input transaction reaches result valid through the input register and then the result register.
// Throughput: one line sample per cycle; output back-pressure stalls only samples that emit.
// A frame yields one result transaction bit_ticks samples (one if bit_ticks is zero) after its last sampled bit.
// Reset (rst_n, asynchronous, active low): receiver idle, line taken as high,
// configuration at defaults, both pipeline registers empty.
module uart_receiver_timed_sampling_core
    import uart_rts_pkg::*;
#(
    parameter int TICK_WIDTH = 23
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 rx_level,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    rx_byte,
    output logic                 parity_bit
);

    rx_cfg_t           cfg;
    rx_result_t        result;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_level_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_parity_reg;
    logic              out_free;
    logic              s1_advance;

    uart_rts_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uart_rts_engine #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_advance),
        .rx_level (s1_level_reg),
        .cfg      (cfg),
        .result   (result)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!result.emit || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
            s1_valid_next = in_valid;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (s1_advance && result.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_level_reg <= rx_level;
        if (s1_advance && result.emit)
        begin
            out_byte_reg   <= result.data;
            out_parity_reg <= result.parity;
        end
    end

    assign out_valid  = out_valid_reg;
    assign rx_byte    = out_byte_reg;
    assign parity_bit = out_parity_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg)
        else $error("stalled sample dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_byte_reg))
        else $error("pending result overwritten");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg ##1 out_valid_reg |-> $past(s1_valid_reg))
        else $error("result appeared without a sample");

endmodule
